>>> hdl/rcidt_pkg.sv
// Shared types, codes and defaults for the reference-counted ID table.
`timescale 1ns / 1ps
`default_nettype none

package rcidt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 16;

    localparam logic [2:0] CMD_QUERY     = 3'd0;
    localparam logic [2:0] CMD_ADD       = 3'd1;
    localparam logic [2:0] CMD_DELETE    = 3'd2;
    localparam logic [2:0] CMD_GET_COUNT = 3'd3;
    localparam logic [2:0] CMD_RESET_ALL = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_DISABLED  = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] thread_id;
        logic        hard_flush;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        present;
        logic [15:0] ref_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_APPLY,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

>>> hdl/rcidt_store.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rcidt_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 49,
    parameter int AW    = 6
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hdl/refcounted_id_table_unit.sv
// Top level of the reference-counted ID table: sequencer, compare unit and hints.
// A scanning command reads the store row by row and ends early when a match is found;
// queries answered by the hit or miss hint, disabled and unknown commands skip the scan.
// Reset_all clears the store, one row cleared per cycle.
// One request at a time; the single store read port sets the pace of the scan.
// After reset a clearing pass writes every store row before the first request is taken.
`timescale 1ns / 1ps
`default_nettype none

module refcounted_id_table_unit #(
    parameter int TABLE_ENTRIES = rcidt_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = rcidt_pkg::COUNT_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    input  wire logic         req_valid,
    output logic              req_ready,
    input  wire rcidt_pkg::req_t req,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output rcidt_pkg::rsp_t   rsp
);

    import rcidt_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = COUNT_BITS;
    localparam int WW = 1 + CW + 32;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam logic [AW:0]   N_CNT = (AW + 1)'(TABLE_ENTRIES);
    localparam logic [AW:0]   LAST_CNT = (AW + 1)'(TABLE_ENTRIES - 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

    state_t state_reg, state_next;

    req_t          req_reg, req_next;
    logic          en_reg, en_next;
    logic          pending_reg, pending_next;
    logic [AW:0]   issue_reg, issue_next;
    logic          rvalid_reg, rvalid_next;
    logic [AW-1:0] ridx_reg, ridx_next;
    logic          found_reg, found_next;
    logic [AW-1:0] found_idx_reg, found_idx_next;
    logic [CW-1:0] found_cnt_reg, found_cnt_next;
    logic          free_reg, free_next;
    logic [AW-1:0] free_idx_reg, free_idx_next;
    rsp_t          res_reg, res_next;
    logic [31:0]   hit_id_reg, hit_id_next;
    logic          hit_vld_reg, hit_vld_next;
    logic [31:0]   miss_id_reg, miss_id_next;
    logic          miss_vld_reg, miss_vld_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [WW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [WW-1:0] rword;

    logic          r_vld;
    logic [CW-1:0] r_cnt;
    logic [31:0]   r_id;
    logic          scan_hit;
    logic          scan_last;
    logic          hint_hit;
    logic          hint_miss;
    logic          issue_more;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] cnt_dec;
    logic          del_free;
    logic [CW+15:0] cnt_ext;
    logic [15:0]   cnt16;

    rcidt_store #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (WW),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rword)
    );

    assign r_vld = rword[WW-1];
    assign r_cnt = rword[WW-2:32];
    assign r_id  = rword[31:0];

    assign scan_hit   = rvalid_reg && r_vld && (r_id == req_reg.thread_id);
    assign scan_last  = rvalid_reg && (ridx_reg == LAST_IDX);
    assign hint_hit   = hit_vld_reg && (hit_id_reg == req_reg.thread_id);
    assign hint_miss  = miss_vld_reg && (miss_id_reg == req_reg.thread_id);
    assign issue_more = (issue_reg < N_CNT);

    assign cnt_inc  = (found_cnt_reg == CMAX) ? found_cnt_reg : found_cnt_reg + 1'b1;
    assign cnt_dec  = (found_cnt_reg != '0) ? found_cnt_reg - 1'b1 : found_cnt_reg;
    assign del_free = (cnt_dec == '0) || req_reg.hard_flush;
    assign cnt_ext  = {16'd0, found_cnt_reg};
    assign cnt16    = (|cnt_ext[CW+15:16]) ? 16'hFFFF : cnt_ext[15:0];

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (issue_reg == LAST_CNT)
                begin
                    state_next = pending_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!en_reg)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    case (req_reg.command)
                        CMD_QUERY:
                        begin
                            state_next = (hint_hit || hint_miss) ? ST_RESP : ST_SCAN;
                        end
                        CMD_ADD, CMD_DELETE, CMD_GET_COUNT: state_next = ST_SCAN;
                        CMD_RESET_ALL:                      state_next = ST_CLEAR;
                        default:                            state_next = ST_RESP;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_last)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // store controls
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = found_idx_reg;
        mem_wdata = {1'b1, cnt_inc, req_reg.thread_id};
        mem_re    = 1'b0;
        mem_raddr = issue_reg[AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = issue_reg[AW-1:0];
                mem_wdata = '0;
            end
            ST_SCAN:
            begin
                mem_re = issue_more;
            end
            ST_APPLY:
            begin
                case (req_reg.command)
                    CMD_ADD:
                    begin
                        if (found_reg)
                        begin
                            mem_we = 1'b1;
                        end
                        else if (free_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = free_idx_reg;
                            mem_wdata = {1'b1, CW'(1), req_reg.thread_id};
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (found_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {~del_free, cnt_dec, req_reg.thread_id};
                        end
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        req_next       = req_reg;
        en_next        = cfg_we ? cfg_wdata : en_reg;
        pending_next   = pending_reg;
        issue_next     = issue_reg;
        rvalid_next    = 1'b0;
        ridx_next      = ridx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        found_cnt_next = found_cnt_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        res_next       = res_reg;
        hit_id_next    = hit_id_reg;
        hit_vld_next   = hit_vld_reg;
        miss_id_next   = miss_id_reg;
        miss_vld_next  = miss_vld_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                issue_next = issue_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next     = req;
                    pending_next = 1'b1;
                end
            end
            ST_DISPATCH:
            begin
                issue_next = '0;
                found_next = 1'b0;
                free_next  = 1'b0;
                res_next   = '{status: STS_OK, present: 1'b0, ref_count: 16'd0};
                if (!en_reg)
                begin
                    res_next.status = STS_DISABLED;
                end
                else
                begin
                    case (req_reg.command)
                        CMD_QUERY:
                        begin
                            res_next.present = hint_hit;
                        end
                        CMD_ADD:
                        begin
                            miss_vld_next = 1'b0;
                        end
                        CMD_DELETE, CMD_GET_COUNT, CMD_RESET_ALL:
                        begin
                            hit_vld_next = 1'b0;
                        end
                        default:
                        begin
                            res_next.status = STS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue_more)
                begin
                    issue_next  = issue_reg + 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = issue_reg[AW-1:0];
                end
                if (scan_hit)
                begin
                    found_next     = 1'b1;
                    found_idx_next = ridx_reg;
                    found_cnt_next = r_cnt;
                end
                else if (rvalid_reg && !r_vld && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = ridx_reg;
                end
            end
            ST_APPLY:
            begin
                case (req_reg.command)
                    CMD_QUERY:
                    begin
                        if (found_reg)
                        begin
                            res_next.present = 1'b1;
                            hit_id_next      = req_reg.thread_id;
                            hit_vld_next     = 1'b1;
                        end
                        else
                        begin
                            miss_id_next  = req_reg.thread_id;
                            miss_vld_next = 1'b1;
                        end
                    end
                    CMD_ADD:
                    begin
                        if (!found_reg && !free_reg)
                        begin
                            res_next.status = STS_FULL;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            res_next.status = STS_NOT_FOUND;
                        end
                    end
                    CMD_GET_COUNT:
                    begin
                        if (found_reg)
                        begin
                            res_next.ref_count = cnt16;
                        end
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    pending_next   = 1'b0;
                end
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            en_reg        <= 1'b0;
            pending_reg   <= 1'b0;
            issue_reg     <= '0;
            rvalid_reg    <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            hit_id_reg    <= '0;
            hit_vld_reg   <= 1'b0;
            miss_id_reg   <= '0;
            miss_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            en_reg        <= en_next;
            pending_reg   <= pending_next;
            issue_reg     <= issue_next;
            rvalid_reg    <= rvalid_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            hit_id_reg    <= hit_id_next;
            hit_vld_reg   <= hit_vld_next;
            miss_id_reg   <= miss_id_next;
            miss_vld_reg  <= miss_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        ridx_reg      <= ridx_next;
        found_idx_reg <= found_idx_next;
        found_cnt_reg <= found_cnt_next;
        free_idx_reg  <= free_idx_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the reference-counted ID table unit.
`timescale 1ns / 1ps

module tb_top;
    import rcidt_pkg::*;

    localparam int TBL_N = TABLE_ENTRIES_DEF;
    localparam logic [15:0] CNT_MAX = 16'hFFFF;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int POOL_N = 72;
    localparam int DIR_N = 25;
    localparam int DIR_DISABLED_ROWS = 2;
    localparam int STUCK_LIMIT = 4000;
    localparam int MAX_REPORTS = 10;
    localparam logic [31:0] SAT_ID = 32'h8000_0001;
    localparam int RAMP_N = 20;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] thread_id;
        logic        hard_flush;
        logic        typed;
        logic [1:0]  status;
        logic        present;
        logic [15:0] ref_count;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    refcounted_id_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted table state
    logic [31:0] tbl_id [TBL_N];
    logic [15:0] tbl_cnt [TBL_N];
    bit          tbl_live [TBL_N];
    logic [31:0] hit_id = '0;
    bit          hit_ok = 1'b0;
    logic [31:0] miss_id = '0;
    bit          miss_ok = 1'b0;
    bit          tbl_enable = 1'b0;

    rsp_t rsp_expected [$];
    rsp_t want;
    rsp_t oldest;
    int   errors = 0;
    int   stuck_cycles = 0;
    int   ready_hold = 0;
    bit   no_idle = 1'b0;
    logic pin_typed = 1'b0;
    rsp_t pin_rsp = '0;

    function automatic int find_entry(logic [31:0] id);
        for (int i = 0; i < TBL_N; i++)
            if (tbl_live[i] && tbl_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic rsp_t predict_table_rsp(req_t r);
        rsp_t o;
        int s;
        int f;
        o = '0;
        s = -1;
        f = -1;
        if (!tbl_enable)
            o.status = STS_DISABLED;
        else
        begin
            case (r.command)
                CMD_QUERY:
                begin
                    if (hit_ok && hit_id == r.thread_id)
                        o.present = 1'b1;
                    else if (miss_ok && miss_id == r.thread_id)
                        o.present = 1'b0;
                    else if (find_entry(r.thread_id) >= 0)
                    begin
                        o.present = 1'b1;
                        hit_id = r.thread_id;
                        hit_ok = 1'b1;
                    end
                    else
                    begin
                        miss_id = r.thread_id;
                        miss_ok = 1'b1;
                    end
                end
                CMD_ADD:
                begin
                    miss_ok = 1'b0;
                    s = find_entry(r.thread_id);
                    if (s >= 0)
                    begin
                        if (tbl_cnt[s] != CNT_MAX)
                            tbl_cnt[s] = tbl_cnt[s] + 16'd1;
                    end
                    else
                    begin
                        for (int i = TBL_N - 1; i >= 0; i--)
                            if (!tbl_live[i])
                                f = i;
                        if (f >= 0)
                        begin
                            tbl_live[f] = 1'b1;
                            tbl_id[f] = r.thread_id;
                            tbl_cnt[f] = 16'd1;
                        end
                        else
                            o.status = STS_FULL;
                    end
                end
                CMD_DELETE:
                begin
                    hit_ok = 1'b0;
                    s = find_entry(r.thread_id);
                    if (s >= 0)
                    begin
                        if (tbl_cnt[s] != 16'd0)
                            tbl_cnt[s] = tbl_cnt[s] - 16'd1;
                        if (tbl_cnt[s] == 16'd0 || r.hard_flush)
                            tbl_live[s] = 1'b0;
                    end
                    else
                        o.status = STS_NOT_FOUND;
                end
                CMD_GET_COUNT:
                begin
                    hit_ok = 1'b0;
                    s = find_entry(r.thread_id);
                    if (s >= 0)
                        o.ref_count = tbl_cnt[s];
                end
                CMD_RESET_ALL:
                begin
                    hit_ok = 1'b0;
                    for (int i = 0; i < TBL_N; i++)
                        tbl_live[i] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        return o;
    endfunction

    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [2:0] pick_cmd(int add_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return CMD_ADD;
        r = $urandom_range(0, 99);
        if (r < 35)
            return CMD_QUERY;
        if (r < 65)
            return CMD_DELETE;
        if (r < 92)
            return CMD_GET_COUNT;
        if (r < 94)
            return CMD_RESET_ALL;
        return 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    // request accept, config write and response check
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            tbl_enable = cfg_wdata;
        if (rst_n && req_valid && req_ready)
        begin
            want = predict_table_rsp(req);
            if (pin_typed)
                want = pin_rsp;
            rsp_expected.push_back(want);
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_expected.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected response status %0d present %0d count %0d",
                             $realtime, rsp.status, rsp.present, rsp.ref_count);
            end
            else
            begin
                oldest = rsp_expected.pop_front();
                if (rsp.status !== oldest.status || rsp.present !== oldest.present
                    || rsp.ref_count !== oldest.ref_count)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: mismatch exp status %0d present %0d count %0d, got %0d %0d %0d",
                                 $realtime, oldest.status, oldest.present, oldest.ref_count,
                                 rsp.status, rsp.present, rsp.ref_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            rsp_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (no_idle || $urandom_range(0, 99) < 75)
            rsp_ready <= 1'b1;
        else
        begin
            rsp_ready <= 1'b0;
            ready_hold <= pause_len() - 1;
        end
    end

    // called and returns at a falling edge
    task automatic send_req(input logic [2:0] cmd, input logic [31:0] id, input logic hard,
                            input logic typed, input rsp_t pin);
        int gap;
        req_t nxt;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        nxt.command = cmd;
        nxt.thread_id = id;
        nxt.hard_flush = hard;
        req <= nxt;
        pin_typed <= typed;
        pin_rsp <= pin;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(req_valid && req_ready));
        @(negedge clk);
    endtask

    task automatic drain_requests();
        req_valid <= 1'b0;
        while (rsp_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_enable(input logic v);
        drain_requests();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    dir_row_t dir_rows [DIR_N];
    logic [31:0] id_pool [POOL_N];
    logic [31:0] fill_ids [TBL_N];

    initial
    begin
        int k;
        int seg;
        int mode;
        int width;
        int add_pct;
        int n_items;
        logic [2:0] cmd;
        logic [31:0] id;
        logic hard;
        rsp_t pin;

        dir_rows = '{
            {CMD_QUERY,     32'h0000_0000, 1'b0, 1'b1, STS_DISABLED,  1'b0, 16'd0},
            {CMD_ADD,       32'hFFFF_FFFF, 1'b1, 1'b1, STS_DISABLED,  1'b0, 16'd0},
            {CMD_QUERY,     32'h0000_0000, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_QUERY,     32'h0000_0000, 1'b1, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_ADD,       32'h0000_0000, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_QUERY,     32'h0000_0000, 1'b0, 1'b1, STS_OK,        1'b1, 16'd0},
            {CMD_QUERY,     32'h0000_0000, 1'b0, 1'b1, STS_OK,        1'b1, 16'd0},
            {CMD_ADD,       32'h0000_0000, 1'b1, 1'b0, STS_OK,        1'b0, 16'd0},
            {CMD_GET_COUNT, 32'h0000_0000, 1'b0, 1'b1, STS_OK,        1'b0, 16'd2},
            {CMD_ADD,       32'hFFFF_FFFF, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_ADD,       32'hFFFF_FFFF, 1'b0, 1'b0, STS_OK,        1'b0, 16'd0},
            {CMD_ADD,       32'hFFFF_FFFF, 1'b0, 1'b0, STS_OK,        1'b0, 16'd0},
            {CMD_DELETE,    32'h0000_0000, 1'b0, 1'b0, STS_OK,        1'b0, 16'd0},
            {CMD_QUERY,     32'h0000_0000, 1'b0, 1'b0, STS_OK,        1'b0, 16'd0},
            {CMD_DELETE,    32'hFFFF_FFFF, 1'b1, 1'b0, STS_OK,        1'b0, 16'd0},
            {CMD_GET_COUNT, 32'hFFFF_FFFF, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_DELETE,    32'hAAAA_AAAA, 1'b0, 1'b1, STS_NOT_FOUND, 1'b0, 16'd0},
            {CMD_ADD,       32'h5555_5555, 1'b1, 1'b0, STS_OK,        1'b0, 16'd0},
            {CMD_GET_COUNT, 32'hAAAA_AAAA, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_SPARE_LO,  32'h5555_5555, 1'b1, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_SPARE_MID, 32'h0000_0000, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_SPARE_HI,  32'hAAAA_AAAA, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_RESET_ALL, 32'hFFFF_FFFF, 1'b1, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_QUERY,     32'h5555_5555, 1'b0, 1'b1, STS_OK,        1'b0, 16'd0},
            {CMD_DELETE,    32'h0000_0000, 1'b1, 1'b1, STS_NOT_FOUND, 1'b0, 16'd0}
        };

        id_pool[0] = 32'h0000_0000;
        id_pool[1] = 32'hFFFF_FFFF;
        for (k = 2; k < POOL_N; k++)
            id_pool[k] = $urandom();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (k = 0; k < DIR_N; k++)
        begin
            if (k == DIR_DISABLED_ROWS)
                set_enable(1'b1);
            pin.status = dir_rows[k].status;
            pin.present = dir_rows[k].present;
            pin.ref_count = dir_rows[k].ref_count;
            send_req(dir_rows[k].command, dir_rows[k].thread_id, dir_rows[k].hard_flush,
                     dir_rows[k].typed, pin);
        end

        // fill every slot, overflow, free one and refill it
        send_req(CMD_RESET_ALL, $urandom(), 1'b0, 1'b0, '0);
        for (k = 0; k < TBL_N; k++)
        begin
            fill_ids[k] = {25'($urandom()), 1'b0, 6'(k)};
            send_req(CMD_ADD, fill_ids[k], 1'($urandom()), 1'b0, '0);
        end
        for (k = 0; k < 3; k++)
            send_req(CMD_ADD, {25'($urandom()), 1'b1, 6'($urandom())}, 1'b0, 1'b0, '0);
        send_req(CMD_QUERY, fill_ids[TBL_N - 1], 1'b0, 1'b0, '0);
        send_req(CMD_ADD, fill_ids[5], 1'b0, 1'b0, '0);
        send_req(CMD_GET_COUNT, fill_ids[5], 1'b0, 1'b0, '0);
        send_req(CMD_DELETE, fill_ids[10], 1'b1, 1'b0, '0);
        send_req(CMD_ADD, {25'($urandom()), 1'b1, 6'($urandom())}, 1'b0, 1'b0, '0);
        send_req(CMD_ADD, {25'($urandom()), 1'b1, 6'($urandom())}, 1'b0, 1'b0, '0);
        send_req(CMD_GET_COUNT, fill_ids[11], 1'b0, 1'b0, '0);

        // ramp one count up back to back, then step it down once and flush it
        no_idle = 1'b1;
        send_req(CMD_RESET_ALL, 32'h0, 1'b0, 1'b0, '0);
        for (k = 0; k < RAMP_N; k++)
            send_req(CMD_ADD, SAT_ID, 1'b0, 1'b0, '0);
        send_req(CMD_GET_COUNT, SAT_ID, 1'b0, 1'b0, '0);
        send_req(CMD_DELETE, SAT_ID, 1'b0, 1'b0, '0);
        send_req(CMD_GET_COUNT, SAT_ID, 1'b0, 1'b0, '0);
        send_req(CMD_DELETE, SAT_ID, 1'b1, 1'b0, '0);
        no_idle = 1'b0;

        for (seg = 0; seg < 13; seg++)
        begin
            mode = seg % 3;
            if (seg == 4 || seg == 10)
                set_enable(1'b0);
            else if (seg == 5 || seg == 11)
                set_enable(1'b1);
            no_idle = ($urandom_range(0, 3) == 0);
            width = (mode == 0) ? 4 : (mode == 1) ? 16 : POOL_N;
            add_pct = (mode == 2) ? 65 : 30;
            n_items = (seg == 4 || seg == 10) ? 40 : 100;
            for (k = 0; k < n_items; k++)
            begin
                cmd = pick_cmd(add_pct);
                id = ($urandom_range(0, 99) < 8) ? $urandom()
                                                  : id_pool[$urandom_range(0, width - 1)];
                hard = ($urandom_range(0, 3) == 0);
                send_req(cmd, id, hard, 1'b0, '0);
            end
        end

        drain_requests();
        repeat (TBL_N + 16) @(negedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
